>>> rtl/ordq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordq_pkg
// Shared constants and codes for the output-restricted deque.
// ----------------------------------------------------------------------------
package ordq_pkg;

	localparam int CAPACITY = 128;
	localparam int WORD_W   = 32;
	localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 8;
	localparam int OP_W     = 2;
	localparam int ST_W     = 2;

	// tdata layout of a result, lowest bit first
	localparam int RES_W     = 3 * WORD_W + OCC_W + 2;
	localparam int RES_PAD_W = ((RES_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_REAR  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_INSPECT    = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

>>> rtl/ordq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordq_ram
// Simple dual-port RAM, registered read, new data on read-during-write.
// ----------------------------------------------------------------------------
module ordq_ram #(
	parameter int DEPTH  = 128,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

>>> rtl/output_restricted_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// output_restricted_deque_top
// Bounded deque in a ring buffer: push at rear or front, pop at front only.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s_axis   in   data_in                                 operation
// m_axis   out  popped, front, rear, occupancy, flags   status
//
// One request per cycle unless m_axis stalls; the result is registered.
// Front and rear words live in registers; the word behind the front is
// prefetched from the slot RAM so a pop never waits on its read port.
// Reset clears pointers and count; slot RAM is not cleared.
// A stalled result holds the input register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module output_restricted_deque_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ordq_pkg::WORD_W-1:0]   s_axis_tdata,  // data_in
	input  logic [ordq_pkg::OP_W-1:0]     s_axis_tuser,  // operation
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// popped_word, front_word, rear_word, occupancy, is_empty, is_full, zero pad
	output logic [ordq_pkg::RES_PAD_W-1:0] m_axis_tdata,
	output logic [ordq_pkg::ST_W-1:0]      m_axis_tuser  // status
);

	import ordq_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] popped;
		logic [WORD_W-1:0] front;
		logic [WORD_W-1:0] rear;
		logic [OCC_W-1:0]  occupancy;
		logic              is_empty;
		logic              is_full;
	} res_t;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	// input register
	logic              valid_s1;
	op_t               op_s1;
	logic [WORD_W-1:0] data_s1;

	// result register
	logic valid_s2;
	res_t res_s2;

	// deque state
	logic [IDX_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] front_q, rear_q;
	logic [WORD_W-1:0] second_word;

	logic              advance;
	logic [IDX_W-1:0]  head_n, tail_n, rd_addr;
	logic [CNT_W-1:0]  count_n;
	logic [WORD_W-1:0] front_n, rear_n;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	res_t              res_n;
	logic              empty_now, full_now;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_LAST : i - 1'b1;
	endfunction

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= op_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata;
		end
	end

	assign empty_now = (count_q == '0);
	assign full_now  = (count_q == CNT_FULL);

	always_comb begin
		head_n      = head_q;
		tail_n      = tail_q;
		count_n     = count_q;
		front_n     = front_q;
		rear_n      = rear_q;
		mem_we      = 1'b0;
		mem_waddr   = tail_q;
		res_n.status = ST_DONE;
		res_n.popped = '0;
		unique case (op_s1)
			OP_PUSH_REAR: begin
				if (full_now) begin
					res_n.status = ST_FULL;
				end else begin
					mem_we    = advance;
					mem_waddr = tail_q;
					tail_n    = ring_next(tail_q);
					count_n   = count_q + 1'b1;
					rear_n    = data_s1;
					if (empty_now) begin
						front_n = data_s1;
					end
				end
			end
			OP_PUSH_FRONT: begin
				if (full_now) begin
					res_n.status = ST_FULL;
				end else begin
					head_n    = ring_prev(head_q);
					mem_we    = advance;
					mem_waddr = head_n;
					count_n   = count_q + 1'b1;
					front_n   = data_s1;
					if (empty_now) begin
						rear_n = data_s1;
					end
				end
			end
			OP_POP_FRONT: begin
				if (empty_now) begin
					res_n.status = ST_EMPTY;
				end else begin
					res_n.popped = front_q;
					head_n       = ring_next(head_q);
					count_n      = count_q - 1'b1;
					front_n      = second_word;
				end
			end
			OP_INSPECT: begin
			end
			default: begin
			end
		endcase
		res_n.is_empty  = (count_n == '0);
		res_n.is_full   = (count_n == CNT_FULL);
		res_n.occupancy = OCC_W'(count_n);
		res_n.front     = res_n.is_empty ? '0 : front_n;
		res_n.rear      = res_n.is_empty ? '0 : rear_n;
	end

	// prefetch the slot behind the new front
	assign rd_addr = ring_next(head_n);

	ordq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_W),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(data_s1),
		.re   (advance),
		.raddr(rd_addr),
		.rdata(second_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (advance) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			front_q <= front_n;
			rear_q  <= rear_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_n;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.status;
	assign m_axis_tdata  = RES_PAD_W'({res_s2.is_full, res_s2.is_empty, res_s2.occupancy,
		res_s2.rear, res_s2.front, res_s2.popped});

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("count above capacity");

	a_ring_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) == (count_q == '0 || count_q == CNT_FULL))
		else $error("head/tail inconsistent with count");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_POP_FRONT && res_n.status == ST_DONE
		|=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not decrement count");

	a_refused_stable: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_n.status != ST_DONE
		|=> $stable(count_q) && $stable(head_q) && $stable(tail_q))
		else $error("refused request changed state");
`endif

endmodule
